// ===== hw/rtl/indexed_list_insert_delete_unit_macros.svh =====
// Assertion macros for the indexed list insert/delete unit.
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ILIST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define ILIST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ilist_pkg.sv =====
// Shared types and constants of the indexed list insert/delete unit.
package ilist_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int POS_W        = 6;
    localparam int VAL_W        = 32;
    localparam int IDX_W        = 6;
    localparam int LEN_W        = 7;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_DUMP   = 3'd2,
        MODE_INSERT = 3'd3,
        MODE_UPDATE = 3'd4,
        MODE_DELETE = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_DUMP,
        S_FIN
    } t_state;

    typedef struct packed {
        t_mode                    mode;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]  element;
        logic [IDX_W-1:0]         element_index;
        t_status                  status;
        logic [LEN_W-1:0]         length;
        logic                     last;
    } t_out_item;

endpackage

// ===== hw/rtl/ilist_ram.sv =====
// Entry storage: one write port, one read port with registered read data.
module ilist_ram
    import ilist_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [VAL_W-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    output logic signed [VAL_W-1:0] o_rd_data
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry; hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/indexed_list_insert_delete_unit.sv =====
// Indexed list with clear, append, dump, insert, update and delete by position.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one command
//   transaction: mode, position and value. Output channel (o_out_valid /
//   i_out_ready / o_out_data) carries result transactions.
//   Clear, append and update, and every failing command, finish in the accept
//   cycle when the output slot is free: the registered result appears in the
//   next cycle and a new command can follow in the next cycle.
//   Insert at position p with n elements moves n-p entries, one per cycle
//   through the single read and write port of the entry memory, then writes
//   the value. Delete at p moves n-p-1 entries, none at the last position.
//   Dump emits one element per cycle while the output is not stalled, after a
//   registered memory read, last set on the final element; an empty list
//   emits nothing. Modes six and seven are dropped without a result.
//   Reset empties the list (count zero); the entry memory is not cleared and
//   needs no sweep. A stalled receiver holds the result in the output
//   register; while idle, the command channel stays ready as a result waits,
//   and the sequencer waits only when its own next result has no free slot.
module indexed_list_insert_delete_unit
    import ilist_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

`include "indexed_list_insert_delete_unit_macros.svh"

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CW1 = CW + 1;
    localparam int PCW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_ptr, n_ptr;
    logic [AW-1:0]           r_pos, n_pos;
    logic signed [VAL_W-1:0] r_val, n_val;
    t_status                 r_status, n_status;
    logic                    r_fin_we, n_fin_we;
    logic                    r_out_valid;
    t_out_item               r_out, n_out;

    logic                    in_acc;
    logic                    slot_free;
    logic                    out_load;
    logic                    full;
    logic                    empty;
    logic [PCW-1:0]          pos_w;
    logic [PCW-1:0]          cnt_w;
    logic [AW-1:0]           pos_a;
    logic [AW-1:0]           cnt_a;
    logic                    imm_resp;
    t_status                 imm_status;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic signed [VAL_W-1:0] rd_data;

    ilist_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Decode handshake and list condition
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign full       = (r_count >= CW'(CAPACITY));
    assign empty      = (r_count == '0);
    assign pos_w      = PCW'(i_in_data.position);
    assign cnt_w      = PCW'(r_count);
    assign pos_a      = AW'(i_in_data.position);
    assign cnt_a      = AW'(r_count);

    // Sequence commands, memory sweeps and result emission
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_pos      = r_pos;
        n_val      = r_val;
        n_status   = r_status;
        n_fin_we   = r_fin_we;
        wr_en      = 1'b0;
        wr_addr    = r_ptr;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = r_ptr;
        out_load   = 1'b0;
        n_out      = '0;
        n_out.status = ST_OK;
        n_out.last = 1'b1;
        imm_resp   = 1'b0;
        imm_status = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.mode)
                        MODE_CLEAR: begin
                            n_count  = '0;
                            imm_resp = 1'b1;
                        end
                        MODE_APPEND: begin
                            imm_resp = 1'b1;
                            if (full) begin
                                imm_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = cnt_a;
                                wr_data = i_in_data.value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        MODE_DUMP: begin
                            if (!empty) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_ptr   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        MODE_INSERT: begin
                            if (full) begin
                                imm_resp   = 1'b1;
                                imm_status = ST_FULL;
                            end else if (pos_w > cnt_w) begin
                                imm_resp   = 1'b1;
                                imm_status = ST_RANGE;
                            end else if (pos_w == cnt_w) begin
                                imm_resp = 1'b1;
                                wr_en    = 1'b1;
                                wr_addr  = pos_a;
                                wr_data  = i_in_data.value;
                                n_count  = r_count + CW'(1);
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = cnt_a - AW'(1);
                                n_ptr    = cnt_a;
                                n_pos    = pos_a;
                                n_val    = i_in_data.value;
                                n_status = ST_OK;
                                n_count  = r_count + CW'(1);
                                n_state  = S_INS;
                            end
                        end
                        MODE_UPDATE: begin
                            imm_resp = 1'b1;
                            if (empty) begin
                                imm_status = ST_EMPTY;
                            end else if (pos_w >= cnt_w) begin
                                imm_status = ST_RANGE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = pos_a;
                                wr_data = i_in_data.value;
                            end
                        end
                        MODE_DELETE: begin
                            if (empty) begin
                                imm_resp   = 1'b1;
                                imm_status = ST_EMPTY;
                            end else if (pos_w >= cnt_w) begin
                                imm_resp   = 1'b1;
                                imm_status = ST_RANGE;
                            end else if ((pos_w + PCW'(1)) < cnt_w) begin
                                rd_en    = 1'b1;
                                rd_addr  = pos_a + AW'(1);
                                n_ptr    = pos_a;
                                n_status = ST_OK;
                                n_count  = r_count - CW'(1);
                                n_state  = S_DEL;
                            end else begin
                                imm_resp = 1'b1;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase

                    // Emit the result now, or park it until the slot frees
                    if (imm_resp) begin
                        if (slot_free) begin
                            out_load     = 1'b1;
                            n_out.status = imm_status;
                            n_out.length = LEN_W'(n_count);
                        end else begin
                            n_status = imm_status;
                            n_fin_we = 1'b0;
                            n_state  = S_FIN;
                        end
                    end
                end
            end
            S_INS: begin
                // Move one entry up; fetch the one below it
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = rd_data;
                if ((r_ptr - AW'(1)) == r_pos) begin
                    n_fin_we = 1'b1;
                    n_state  = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr - AW'(1) - AW'(1);
                    n_ptr   = r_ptr - AW'(1);
                end
            end
            S_DEL: begin
                // Move one entry down; fetch the one above the next target
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = rd_data;
                if ((CW1'(r_ptr) + CW1'(1)) < CW1'(r_count)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr + AW'(1) + AW'(1);
                    n_ptr   = r_ptr + AW'(1);
                end else begin
                    n_fin_we = 1'b0;
                    n_state  = S_FIN;
                end
            end
            S_DUMP: begin
                // Emit one element and prefetch the next
                if (slot_free) begin
                    out_load            = 1'b1;
                    n_out.element       = rd_data;
                    n_out.element_index = IDX_W'(r_ptr);
                    n_out.length        = LEN_W'(r_count);
                    n_out.last          = ((CW1'(r_ptr) + CW1'(1)) == CW1'(r_count));
                    if (n_out.last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_ptr + AW'(1);
                        n_ptr   = r_ptr + AW'(1);
                    end
                end
            end
            S_FIN: begin
                // Place the value of an insert, if any, and emit the status result
                wr_en   = r_fin_we;
                wr_addr = r_pos;
                wr_data = r_val;
                if (slot_free) begin
                    out_load     = 1'b1;
                    n_out.status = r_status;
                    n_out.length = LEN_W'(r_count);
                    n_fin_we     = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_fin_we <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_fin_we <= n_fin_we;
        end
    end

    // Hold command context
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `ILIST_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `ILIST_ASSERT_NOW(a_load_free, out_load, !r_out_valid || i_out_ready, "result overwritten")
    `ILIST_ASSERT_NOW(a_dump_idx, r_state == S_DUMP, CW1'(r_ptr) < CW1'(r_count), "dump past end")
    `ILIST_ASSERT_NOW(a_port_clash, wr_en && rd_en, wr_addr != rd_addr, "read and write collide")
    `ILIST_ASSERT_NEXT(a_ins_len, r_state == S_INS && n_state == S_FIN, r_fin_we, "insert value lost")

endmodule
